@@ hdl/fdc16_pkg.sv @@
package fdc16_pkg;

  // header layout, byte offsets from the start of a frame
  localparam int HEADER_BYTES = 14;
  localparam int HDR_MAGIC_HI = 0;
  localparam int HDR_MAGIC_LO = 1;
  localparam int HDR_LEN_HI   = 3;
  localparam int HDR_LEN_LO   = 4;
  localparam int HDR_TYPE     = 5;
  localparam int HDR_DEV_FIRST = 6;
  localparam int HDR_DEV_LAST  = 9;
  localparam int HDR_SEQ_FIRST = 10;
  localparam int HDR_SEQ_LAST  = 11;
  localparam int HDR_CRC_HI   = 12;
  localparam int HDR_CRC_LO   = 13;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    STAT_GOOD      = 2'd0,
    STAT_BAD_MAGIC = 2'd1,
    STAT_BAD_LEN   = 2'd2,
    STAT_BAD_CRC   = 2'd3
  } status_t;

  // what an accepted byte caused
  typedef enum logic [1:0] {
    EV_NONE,
    EV_ERR,
    EV_EMPTY,
    EV_FRAME
  } evt_t;

  // which kind of result the datapath presents
  typedef enum logic [1:0] {
    OM_NONE,
    OM_ERR,
    OM_EMPTY,
    OM_BYTE
  } out_mode_t;

  typedef enum logic [2:0] {
    S_RECV,
    S_ERR,
    S_EMPTY,
    S_READ,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      rd_en;
    logic      rd_clr;
    logic      rd_inc;
    out_mode_t mode;
  } dp_cmd_t;

  typedef struct packed {
    evt_t evt;
    logic play_last;
  } dp_stat_t;

  // reflected crc-16, one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/fdc16_rx_if.sv @@
interface fdc16_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/fdc16_cfg_if.sv @@
interface fdc16_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink (input valid, input start_marker, output ready);
endinterface

@@ hdl/fdc16_res_if.sv @@
interface fdc16_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [31:0] device_id;
  logic [15:0] sequence_res;
  logic [6:0]  payload_length;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        last;

  modport source (output valid, output status, output frame_type, output device_id,
                  output sequence_res, output payload_length, output payload_byte,
                  output byte_valid, output last, input ready);
  modport sink (input valid, input status, input frame_type, input device_id,
                input sequence_res, input payload_length, input payload_byte,
                input byte_valid, input last, output ready);
endinterface

@@ hdl/fdc16_ctrl.sv @@
module fdc16_ctrl
  import fdc16_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_RECV: begin
        if (in_valid) begin
          case (stat.evt)
            EV_ERR:   state_next = S_ERR;
            EV_EMPTY: state_next = S_EMPTY;
            EV_FRAME: state_next = S_READ;
            default:  state_next = S_RECV;
          endcase
        end
      end
      S_ERR, S_EMPTY: begin
        if (out_ready) state_next = S_RECV;
      end
      S_READ: state_next = S_SHOW;
      S_SHOW: begin
        if (out_ready) state_next = stat.play_last ? S_RECV : S_READ;
      end
      default: state_next = S_RECV;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.rd_clr = 1'b0;
    cmd.rd_inc = 1'b0;
    cmd.mode   = OM_NONE;
    case (state)
      S_RECV: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.rd_clr = 1'b1;
      end
      S_ERR:   cmd.mode = OM_ERR;
      S_EMPTY: cmd.mode = OM_EMPTY;
      S_READ:  cmd.rd_en = 1'b1;
      S_SHOW: begin
        cmd.mode   = OM_BYTE;
        cmd.rd_inc = out_ready;
      end
      default: cmd.mode = OM_NONE;
    endcase
  end

endmodule

@@ hdl/fdc16_dp.sv @@
module fdc16_dp
  import fdc16_pkg::*;
#(
  parameter int PAYLOAD_CAP = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_magic,
  input  logic [7:0]  rx_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [7:0]  frame_type,
  output logic [31:0] device_id,
  output logic [15:0] sequence_res,
  output logic [6:0]  payload_length,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        last
);

  localparam int LEN_W  = $clog2(PAYLOAD_CAP + 1);
  localparam int ADDR_W = (PAYLOAD_CAP > 1) ? $clog2(PAYLOAD_CAP) : 1;
  localparam int POS_W  = $clog2(HEADER_BYTES + PAYLOAD_CAP);

  logic [15:0]       magic;
  logic [POS_W-1:0]  pos, pos_next;
  logic [15:0]       crc, crc_base, crc_new;
  logic              absorb;
  logic [7:0]        marker_hi;
  logic [15:0]       word, rcrc_word;
  logic [LEN_W-1:0]  held_length;
  logic [7:0]        held_type;
  logic [31:0]       held_dev;
  logic [15:0]       held_seq;
  logic [15:0]       rcrc;
  logic [POS_W-1:0]  pay_off, pay_cnt;
  logic              in_payload;
  evt_t              evt;
  status_t           err_next, err_code;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        mem_q;
  logic [LEN_W+6:0]  len_ext;
  logic [7:0]        mem [PAYLOAD_CAP];

  always_comb begin
    crc_base   = (pos == '0) ? CRC_INIT : crc;
    absorb     = (pos < POS_W'(HDR_CRC_HI)) || (pos >= POS_W'(HEADER_BYTES));
    crc_new    = absorb ? crc16_byte(crc_base, rx_byte) : crc_base;
    word       = {marker_hi, rx_byte};
    rcrc_word  = {rcrc[7:0], rx_byte};
    pay_off    = pos - POS_W'(HEADER_BYTES);
    pay_cnt    = pay_off + POS_W'(1);
    in_payload = (pos >= POS_W'(HEADER_BYTES));
    evt        = EV_NONE;
    err_next   = STAT_BAD_MAGIC;
    if (pos == POS_W'(HDR_MAGIC_LO)) begin
      if (word != magic) evt = EV_ERR;
    end else if (pos == POS_W'(HDR_LEN_LO)) begin
      if (32'(word) > 32'(PAYLOAD_CAP)) begin
        evt      = EV_ERR;
        err_next = STAT_BAD_LEN;
      end
    end else if (pos == POS_W'(HDR_CRC_LO)) begin
      if (held_length == '0) begin
        evt      = (crc_new != rcrc_word) ? EV_ERR : EV_EMPTY;
        err_next = STAT_BAD_CRC;
      end
    end else if (in_payload && (pay_cnt >= POS_W'(held_length))) begin
      evt      = (crc_new != rcrc) ? EV_ERR : EV_FRAME;
      err_next = STAT_BAD_CRC;
    end
    pos_next = (evt == EV_NONE) ? pos + POS_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic  <= '0;
      pos    <= '0;
      crc    <= CRC_INIT;
      rd_idx <= '0;
    end else begin
      if (cfg_we) magic <= cfg_magic;
      if (cmd.accept) begin
        pos <= pos_next;
        crc <= crc_new;
      end
      if (cmd.rd_clr) begin
        rd_idx <= '0;
      end else if (cmd.rd_inc) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  // header capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (evt == EV_ERR) err_code <= err_next;
      if (pos == POS_W'(HDR_MAGIC_HI) || pos == POS_W'(HDR_LEN_HI)) marker_hi <= rx_byte;
      if (pos == POS_W'(HDR_LEN_LO)) held_length <= word[LEN_W-1:0];
      if (pos == POS_W'(HDR_TYPE)) held_type <= rx_byte;
      if (pos >= POS_W'(HDR_DEV_FIRST) && pos <= POS_W'(HDR_DEV_LAST)) begin
        held_dev <= {held_dev[23:0], rx_byte};
      end
      if (pos >= POS_W'(HDR_SEQ_FIRST) && pos <= POS_W'(HDR_SEQ_LAST)) begin
        held_seq <= {held_seq[7:0], rx_byte};
      end
      if (pos == POS_W'(HDR_CRC_HI) || pos == POS_W'(HDR_CRC_LO)) rcrc <= rcrc_word;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.accept && in_payload) mem[pay_off[ADDR_W-1:0]] <= rx_byte;
    if (cmd.rd_en) mem_q <= mem[rd_idx];
  end

  assign stat.evt       = evt;
  assign stat.play_last = (LEN_W'(rd_idx) + LEN_W'(1)) == held_length;
  assign len_ext        = {7'd0, held_length};

  always_comb begin
    out_valid      = 1'b0;
    status         = STAT_GOOD;
    frame_type     = '0;
    device_id      = '0;
    sequence_res   = '0;
    payload_length = '0;
    payload_byte   = '0;
    byte_valid     = 1'b0;
    last           = 1'b0;
    case (cmd.mode)
      OM_ERR: begin
        out_valid = 1'b1;
        status    = err_code;
        last      = 1'b1;
      end
      OM_EMPTY: begin
        out_valid    = 1'b1;
        frame_type   = held_type;
        device_id    = held_dev;
        sequence_res = held_seq;
        last         = 1'b1;
      end
      OM_BYTE: begin
        out_valid      = 1'b1;
        frame_type     = held_type;
        device_id      = held_dev;
        sequence_res   = held_seq;
        payload_length = len_ext[6:0];
        payload_byte   = mem_q;
        byte_valid     = 1'b1;
        last           = stat.play_last;
      end
      default: out_valid = 1'b0;
    endcase
  end

endmodule

@@ hdl/frame_deframer_crc16_check_unit.sv @@
// frame deframer with crc-16 check. received bytes come in on rx, one per
// transaction, and are parsed as a 14-byte big-endian header (magic, version,
// length, type, device id, sequence, crc) followed by length payload bytes.
// a reflected crc-16 (poly 0xa001, init 0xffff) covers header bytes 0 to 11
// and the payload, and is compared with the header crc. a good frame yields
// one result per payload byte (or one result with byte_valid low for an
// empty payload), each carrying the header fields, last set on the final
// one. bad magic, a length above PAYLOAD_CAP, or a crc mismatch yields
// a single error result and the parser restarts at byte 0 with the next
// byte; there is no sliding search for the marker. while a frame comes in,
// one byte is taken per cycle. once the frame ends, rx stalls until all
// its results are taken: an error or empty-frame result is shown the
// cycle after the closing byte, and each payload result needs a read of
// the payload store, then the result on res, held until res is ready.
// the start marker is written on cfg, which is always ready; write it only
// while the block is idle.
module frame_deframer_crc16_check_unit
  import fdc16_pkg::*;
#(
  parameter int PAYLOAD_CAP = 64
) (
  input logic          clk,
  input logic          rst,
  fdc16_cfg_if.sink    cfg,
  fdc16_rx_if.sink     rx,
  fdc16_res_if.source  res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register write never stalls
  assign cfg.ready = 1'b1;

  // sequencer: receive, then replay results
  fdc16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // header capture, crc, payload store and result formatting
  fdc16_dp #(
    .PAYLOAD_CAP (PAYLOAD_CAP)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_magic      (cfg.start_marker),
    .rx_byte        (rx.rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (res.valid),
    .status         (res.status),
    .frame_type     (res.frame_type),
    .device_id      (res.device_id),
    .sequence_res   (res.sequence_res),
    .payload_length (res.payload_length),
    .payload_byte   (res.payload_byte),
    .byte_valid     (res.byte_valid),
    .last           (res.last)
  );

endmodule

@@ tb/sv/frame_deframer_crc16_check_unit_checker.sv @@
`timescale 1ns / 1ps

module frame_deframer_crc16_check_unit_checker
  import fdc16_pkg::*;
#(
  parameter int PAYLOAD_CAP = 64
) (
  input  logic  clk,
  input  logic  rst,
  fdc16_cfg_if  cfg,
  fdc16_rx_if   rx,
  fdc16_res_if  res,
  output int    mismatches,
  output int    results_owed
);

  localparam logic [15:0] CRC_SEED       = 16'hFFFF;
  localparam logic [15:0] CRC_REFLECTED  = 16'hA001;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_type;
    logic [31:0] device_id;
    logic [15:0] sequence_res;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;
  } frame_result_t;

  frame_result_t frame_results_due[$];
  int            bad_count;

  // parser copy
  logic [15:0] magic_reg;
  int          hdr_pos;
  logic [15:0] crc_acc;
  logic [15:0] shift_acc;
  logic [15:0] len_held;
  logic [7:0]  type_held;
  logic [31:0] dev_acc;
  logic [15:0] seq_acc;
  logic [15:0] crc_rx;
  logic [7:0]  payload_mem [PAYLOAD_CAP];

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CRC_REFLECTED) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic void push_error(input status_t code);
    frame_result_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    frame_results_due.push_back(r);
    hdr_pos = 0;
  endfunction

  function automatic void push_frame();
    frame_result_t r;
    hdr_pos = 0;
    if (crc_acc != crc_rx) begin
      push_error(STAT_BAD_CRC);
      return;
    end
    r = '0;
    r.status = STAT_GOOD;
    r.frame_type = type_held;
    r.device_id = dev_acc;
    r.sequence_res = seq_acc;
    if (len_held == 0) begin
      r.last = 1'b1;
      frame_results_due.push_back(r);
      return;
    end
    for (int k = 0; k < int'(len_held); k++) begin
      r.payload_length = len_held[6:0];
      r.payload_byte = payload_mem[k];
      r.byte_valid = 1'b1;
      r.last = (k == int'(len_held) - 1);
      frame_results_due.push_back(r);
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    int pos;
    int idx;
    pos = hdr_pos;
    if (pos == 0) begin
      crc_acc = CRC_SEED;
      shift_acc = '0;
    end
    // the two crc bytes stay out of the running crc
    if (pos < HDR_CRC_HI || pos >= HEADER_BYTES) begin
      crc_acc = crc_next(crc_acc, b);
    end
    hdr_pos = pos + 1;
    if (pos == HDR_MAGIC_HI || pos == HDR_LEN_HI) begin
      shift_acc = {8'h00, b};
    end else if (pos == HDR_MAGIC_LO) begin
      shift_acc = {shift_acc[7:0], b};
      if (shift_acc != magic_reg) begin
        push_error(STAT_BAD_MAGIC);
      end
    end else if (pos == HDR_LEN_LO) begin
      shift_acc = {shift_acc[7:0], b};
      if (shift_acc > PAYLOAD_CAP) begin
        push_error(STAT_BAD_LEN);
      end else begin
        len_held = shift_acc;
      end
    end else if (pos == HDR_TYPE) begin
      type_held = b;
    end else if (pos >= HDR_DEV_FIRST && pos <= HDR_DEV_LAST) begin
      dev_acc = {dev_acc[23:0], b};
    end else if (pos >= HDR_SEQ_FIRST && pos <= HDR_SEQ_LAST) begin
      seq_acc = {seq_acc[7:0], b};
    end else if (pos == HDR_CRC_HI) begin
      crc_rx = {8'h00, b};
    end else if (pos == HDR_CRC_LO) begin
      crc_rx = {crc_rx[7:0], b};
      if (len_held == 0) begin
        push_frame();
      end
    end else if (pos >= HEADER_BYTES) begin
      idx = pos - HEADER_BYTES;
      if (idx < PAYLOAD_CAP) begin
        payload_mem[idx] = b;
      end
      if (idx + 1 >= int'(len_held)) begin
        push_frame();
      end
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      bad_count++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (frame_results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d byte %0h last %0b",
               $time, res.status, res.payload_byte, res.last);
      bad_count++;
      return;
    end
    want = frame_results_due.pop_front();
    compare_field("status", want.status, res.status);
    compare_field("frame_type", want.frame_type, res.frame_type);
    compare_field("device_id", want.device_id, res.device_id);
    compare_field("sequence_res", want.sequence_res, res.sequence_res);
    compare_field("payload_length", want.payload_length, res.payload_length);
    compare_field("payload_byte", want.payload_byte, res.payload_byte);
    compare_field("byte_valid", want.byte_valid, res.byte_valid);
    compare_field("last", want.last, res.last);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      magic_reg = '0;
      hdr_pos = 0;
      crc_acc = CRC_SEED;
      shift_acc = '0;
      len_held = '0;
      type_held = '0;
      dev_acc = '0;
      seq_acc = '0;
      crc_rx = '0;
      bad_count = 0;
      frame_results_due.delete();
      mismatches <= 0;
      results_owed <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        magic_reg = cfg.start_marker;
      end
      if (rx.valid && rx.ready) begin
        parse_rx_byte(rx.rx_byte);
      end
      if (res.valid && res.ready) begin
        check_result();
      end
      mismatches <= bad_count;
      results_owed <= frame_results_due.size();
    end
  end

endmodule

@@ tb/sv/frame_deframer_crc16_check_unit_test.sv @@
`timescale 1ns / 1ps

module frame_deframer_crc16_check_unit_test
  import fdc16_pkg::*;
;

  localparam int PAYLOAD_CAP   = 64;
  // give the block room to settle after the results are in
  localparam int SETTLE_CYCLES = 16;
  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT    = 1000;

  logic clk;
  logic rst;

  fdc16_cfg_if cfg ();
  fdc16_rx_if  rx ();
  fdc16_res_if res ();

  int mismatch_count;
  int results_owed;
  int idle_cycles;

  // bytes of the frame (or broken fragment) about to go out on rx
  logic [7:0] frame_bytes[$];
  logic [15:0] cur_magic;
  // when set, the side runs back to back with no idle cycles
  bit rx_eager = 1'b0;
  bit sink_eager = 1'b0;

  frame_deframer_crc16_check_unit #(
    .PAYLOAD_CAP(PAYLOAD_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .rx(rx),
    .res(res)
  );

  // watches all three channels, predicts the results and scores them
  frame_deframer_crc16_check_unit_checker #(
    .PAYLOAD_CAP(PAYLOAD_CAP)
  ) chk (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .rx(rx),
    .res(res),
    .mismatches(mismatch_count),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang detection: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("frame_deframer_crc16_check_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each transaction, with eager stretches
  initial begin : result_sink
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        sink_eager = !sink_eager;
      end
      stall = sink_eager ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
    end
  end

  // one rx transaction; valid stays high into the next byte when there is no gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = rx_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  // hold rx off until every predicted result has come back
  task automatic wait_for_results();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // only called with the parser at byte 0 and nothing in flight
  task automatic write_magic(input logic [15:0] m);
    cfg.valid <= 1'b1;
    cfg.start_marker <= m;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cur_magic = m;
  endtask

  // well-formed frame with random version, type, device id, sequence and payload
  task automatic build_frame(input logic [15:0] magic, input int len);
    logic [15:0] len16;
    logic [15:0] crc;
    logic [7:0]  body[$];
    len16 = 16'(len);
    frame_bytes = '{magic[15:8], magic[7:0], 8'($urandom), len16[15:8], len16[7:0]};
    // type, four device id bytes, two sequence bytes
    repeat (7) frame_bytes.push_back(8'($urandom));
    repeat (len) body.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_bytes[i]) begin
      crc = crc16_byte(crc, frame_bytes[i]);
    end
    foreach (body[i]) begin
      crc = crc16_byte(crc, body[i]);
    end
    // crc goes out big-endian
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    foreach (body[i]) begin
      frame_bytes.push_back(body[i]);
    end
  endtask

  // mostly short payloads, a few mid-size, rarely near the maximum
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return $urandom_range(17, PAYLOAD_CAP);
    end
    if (r < 4) begin
      return $urandom_range(7, 16);
    end
    return $urandom_range(0, 6);
  endfunction

  // every fragment sent here leaves the parser back at byte 0
  task automatic run_random_frames(input int byte_budget);
    int sent;
    int pick;
    int spot;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [15:0] bad_len;
    sent = 0;
    while (sent < byte_budget) begin
      rx_eager = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        // good frame
        build_frame(cur_magic, pick_length());
      end else if (pick < 13) begin
        // crc field damaged
        build_frame(cur_magic, pick_length());
        frame_bytes[HDR_CRC_LO] ^= 8'($urandom_range(1, 255));
      end else if (pick < 15) begin
        // any byte after the length damaged, crc no longer matches
        build_frame(cur_magic, pick_length());
        spot = $urandom_range(HDR_TYPE, frame_bytes.size() - 1);
        frame_bytes[spot] ^= 8'($urandom_range(1, 255));
      end else if (pick < 17) begin
        // wrong marker, sometimes with the first byte right
        b0 = $urandom_range(0, 1) ? cur_magic[15:8] : 8'($urandom);
        b1 = 8'($urandom);
        if ({b0, b1} == cur_magic) begin
          b1 = ~b1;
        end
        frame_bytes = '{b0, b1};
      end else begin
        // length above the payload store
        bad_len = $urandom_range(0, 1) ? 16'(PAYLOAD_CAP + 1) :
                  16'($urandom_range(PAYLOAD_CAP + 1, 65535));
        frame_bytes = '{cur_magic[15:8], cur_magic[7:0], 8'($urandom),
                        bad_len[15:8], bad_len[7:0]};
      end
      send_frame();
      sent += frame_bytes.size();
      if ($urandom_range(0, 7) == 0) begin
        wait_for_results();
      end
    end
  endtask

  task automatic end_phase();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    rx.valid <= 1'b0;
    rx.rx_byte <= '0;
    cfg.valid <= 1'b0;
    cfg.start_marker <= '0;
    cur_magic = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, marker all zeros
    write_magic(16'h0000);
    // bad marker built of all-ones bytes
    frame_bytes = '{8'hFF, 8'hFF};
    send_frame();
    // length one above the limit, version byte all ones
    frame_bytes = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'(PAYLOAD_CAP + 1)};
    send_frame();
    // empty payload, good crc
    build_frame(cur_magic, 0);
    send_frame();
    // empty payload, crc mismatch
    build_frame(cur_magic, 0);
    frame_bytes[HDR_CRC_HI] ^= 8'h80;
    send_frame();
    end_phase();

    // marker all ones
    write_magic(16'hFFFF);
    rx_eager = 1'b0;
    run_random_frames(20);
    end_phase();

    write_magic(16'($urandom));
    run_random_frames(20);
    end_phase();

    // last setting: random frames, then raw noise that may stop mid-frame
    write_magic(16'($urandom));
    run_random_frames(15);
    rx_eager = 1'b0;
    repeat (10) send_byte(8'($urandom));
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("frame_deframer_crc16_check_unit test passed");
    end else begin
      $display("frame_deframer_crc16_check_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/fdc16_pkg.sv
hdl/fdc16_rx_if.sv
hdl/fdc16_cfg_if.sv
hdl/fdc16_res_if.sv
hdl/fdc16_ctrl.sv
hdl/fdc16_dp.sv
hdl/frame_deframer_crc16_check_unit.sv
tb/sv/frame_deframer_crc16_check_unit_checker.sv
tb/sv/frame_deframer_crc16_check_unit_test.sv
